>>> rtl/lsc_pkg.sv
// Shared types and constants for the slot cache tag and policy engine.
package lsc_pkg;

    localparam int KEY_W  = 64;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 32;
    localparam int GEN_W  = 32;
    localparam int CNT_W  = 5;

    localparam logic [TIME_W-1:0] STAMP_MAX = '1;

    typedef enum logic [1:0] {
        REQ_LOOKUP  = 2'd0,
        REQ_RECHECK = 2'd1,
        REQ_CLAIM   = 2'd2,
        REQ_FINISH  = 2'd3
    } req_t;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        req_t              req;
        logic [KEY_W-1:0]  key;
        logic              key_empty;
        logic              fetch_allowed;
        logic [SLOT_W-1:0] target_slot;
        logic              decode_ok;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    // Handshake between the front queue and the back engine.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

endpackage

>>> rtl/lsc_front.sv
// Front end: accepts request words, masks and classifies them, and queues them.
module lsc_front
    import lsc_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [KEY_W-1:0]  s_key,
    input  logic              s_fetch_allowed,
    input  logic [SLOT_W-1:0] s_target_slot,
    input  logic              s_decode_ok,
    input  logic [TIME_W-1:0] s_now_ms,
    output queue_out_t        q_out,
    input  logic              q_pop
);

    item_t            entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [KEY_W-1:0] key_mask;
    item_t            classified;
    logic             push;
    logic             pop;

    always_comb begin
        for (int i = 0; i < KEY_W; i++) begin
            key_mask[i] = (i < KEY_BITS);
        end
    end

    always_comb begin
        classified.req           = req_t'(s_req_type);
        classified.key           = s_key & key_mask;
        classified.key_empty     = ((s_key & key_mask) == '0);
        classified.fetch_allowed = s_fetch_allowed;
        classified.target_slot   = s_target_slot;
        classified.decode_ok     = s_decode_ok;
        classified.now_ms        = s_now_ms;
    end

    assign s_ready      = (count_reg != 2'd2);
    assign push         = s_valid && s_ready;
    assign pop          = q_pop && (count_reg != 2'd0);
    assign q_out.valid  = (count_reg != 2'd0);
    assign q_out.item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                entry_reg[wr_ptr_reg] <= classified;
                wr_ptr_reg            <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> rtl/lsc_back.sv
// Back end: scans the slot and bad-key stores, applies a request and registers its result.
module lsc_back
    import lsc_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int BAD_DEPTH  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  slots_in_use,
    input  queue_out_t        q_in,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_fetch_request,
    output logic              m_key_is_bad,
    output logic              m_already_have,
    output logic [GEN_W-1:0]  m_generation
);

    localparam int SLOT_IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BAD_IW   = (BAD_DEPTH > 1) ? $clog2(BAD_DEPTH) : 1;
    localparam int SCAN_LEN = (SLOT_COUNT > BAD_DEPTH) ? SLOT_COUNT : BAD_DEPTH;
    localparam int SCAN_W   = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
    localparam int TS_W     = (SLOT_IW > SLOT_W) ? SLOT_IW : SLOT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    item_t               item_reg;
    logic [SCAN_W-1:0]   scan_reg;

    logic [KEY_W-1:0]    tag_reg      [SLOT_COUNT];
    logic                ready_reg    [SLOT_COUNT];
    logic [TIME_W-1:0]   last_use_reg [SLOT_COUNT];
    logic [KEY_W-1:0]    bad_reg      [BAD_DEPTH];
    logic [BAD_IW-1:0]   bad_ptr_reg;
    logic [GEN_W-1:0]    gen_reg;

    logic                found_reg;
    logic [SLOT_IW-1:0]  found_idx_reg;
    logic                vic_found_reg;
    logic [SLOT_IW-1:0]  vic_idx_reg;
    logic [SLOT_IW-1:0]  best_idx_reg;
    logic [TIME_W-1:0]   oldest_reg;
    logic                bad_found_reg;

    logic [31:0]         active_n;
    logic                slot_live;
    logic                bad_live;
    logic [SLOT_IW-1:0]  slot_idx;
    logic [BAD_IW-1:0]   bad_idx;
    logic [SLOT_IW-1:0]  victim;
    logic [TS_W-1:0]     tslot_ext;
    logic                out_free;

    assign active_n  = (32'(slots_in_use) > 32'(SLOT_COUNT)) ? 32'(SLOT_COUNT)
                                                             : 32'(slots_in_use);
    assign slot_live = (32'(scan_reg) < active_n);
    assign bad_live  = (32'(scan_reg) < 32'(BAD_DEPTH));
    assign slot_idx  = SLOT_IW'(scan_reg);
    assign bad_idx   = BAD_IW'(scan_reg);
    assign victim    = vic_found_reg ? vic_idx_reg : best_idx_reg;
    assign tslot_ext = TS_W'(item_reg.target_slot);
    assign out_free  = !m_valid || m_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_in.valid;
    assign m_generation = gen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid     <= 1'b0;
            bad_ptr_reg <= '0;
            gen_reg     <= GEN_W'(1);
            scan_reg    <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                tag_reg[i]      <= '0;
                ready_reg[i]    <= 1'b0;
                last_use_reg[i] <= '0;
            end
            for (int i = 0; i < BAD_DEPTH; i++) begin
                bad_reg[i] <= '0;
            end
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_in.valid) begin
                        item_reg      <= q_in.item;
                        scan_reg      <= '0;
                        found_reg     <= 1'b0;
                        found_idx_reg <= '0;
                        vic_found_reg <= 1'b0;
                        vic_idx_reg   <= '0;
                        best_idx_reg  <= '0;
                        oldest_reg    <= STAMP_MAX;
                        bad_found_reg <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (slot_live) begin
                        if (!found_reg && ready_reg[slot_idx]
                            && (tag_reg[slot_idx] == item_reg.key)) begin
                            found_reg     <= 1'b1;
                            found_idx_reg <= slot_idx;
                        end
                        if (!vic_found_reg) begin
                            if (!ready_reg[slot_idx]) begin
                                vic_found_reg <= 1'b1;
                                vic_idx_reg   <= slot_idx;
                            end else if (last_use_reg[slot_idx] < oldest_reg) begin
                                oldest_reg   <= last_use_reg[slot_idx];
                                best_idx_reg <= slot_idx;
                            end
                        end
                    end
                    if (bad_live && (bad_reg[bad_idx] != '0)
                        && (bad_reg[bad_idx] == item_reg.key)) begin
                        bad_found_reg <= 1'b1;
                    end
                    if (32'(scan_reg) == 32'(SCAN_LEN - 1)) begin
                        state_reg <= ST_EXEC;
                    end else begin
                        scan_reg <= scan_reg + SCAN_W'(1);
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        m_valid         <= 1'b1;
                        m_hit           <= 1'b0;
                        m_slot          <= '0;
                        m_fetch_request <= 1'b0;
                        m_key_is_bad    <= 1'b0;
                        m_already_have  <= 1'b0;
                        unique case (item_reg.req)
                            REQ_LOOKUP: begin
                                if (!item_reg.key_empty) begin
                                    if (found_reg) begin
                                        last_use_reg[found_idx_reg] <= item_reg.now_ms;
                                        m_hit  <= 1'b1;
                                        m_slot <= SLOT_W'(found_idx_reg);
                                    end else begin
                                        m_key_is_bad    <= bad_found_reg;
                                        m_fetch_request <= !bad_found_reg
                                                           && item_reg.fetch_allowed;
                                    end
                                end
                            end
                            REQ_RECHECK: begin
                                m_key_is_bad   <= bad_found_reg;
                                m_already_have <= found_reg || bad_found_reg;
                            end
                            REQ_CLAIM: begin
                                ready_reg[victim] <= 1'b0;
                                tag_reg[victim]   <= item_reg.key;
                                m_slot            <= SLOT_W'(victim);
                            end
                            REQ_FINISH: begin
                                if (item_reg.decode_ok) begin
                                    if (32'(tslot_ext) < 32'(SLOT_COUNT)) begin
                                        ready_reg[SLOT_IW'(tslot_ext)]    <= 1'b1;
                                        last_use_reg[SLOT_IW'(tslot_ext)] <= item_reg.now_ms;
                                    end
                                    gen_reg <= gen_reg + GEN_W'(1);
                                end else if (!bad_found_reg) begin
                                    bad_reg[bad_ptr_reg] <= item_reg.key;
                                    if (32'(bad_ptr_reg) == 32'(BAD_DEPTH - 1)) begin
                                        bad_ptr_reg <= '0;
                                    end else begin
                                        bad_ptr_reg <= bad_ptr_reg + BAD_IW'(1);
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/lru_slot_cache_with_bad_key_ring_top.sv
// Top level of the slot cache tag and policy engine with its bad-key ring.
//
//  Channel  Ports          Direction  Carries
//  s_       valid/ready    in         one request word per handshake
//  m_       valid/ready    out        one result word per request word
//  APB      psel..prdata   in/out     slots_in_use register at byte address 0
//
// Each request word passes through the back end in order: it is taken from the queue,
// then scanned over every slot and ring entry, and then applied with its result loaded.
// The scan steps over one slot and one ring entry per cycle.
// A two-word queue lets the front accept words while the back scans, and the result
// register frees the back from a stalled m_ready until the next result is due.
// Reset (aresetn low at a clock edge) clears all tags, ready bits, stamps and
// ring entries at once, sets the generation to one and slots_in_use to 16.
module lru_slot_cache_with_bad_key_ring_top
    import lsc_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int BAD_DEPTH  = 16,
    parameter int KEY_BITS   = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Request channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [KEY_W-1:0]  s_key,
    input  logic              s_fetch_allowed,
    input  logic [SLOT_W-1:0] s_target_slot,
    input  logic              s_decode_ok,
    input  logic [TIME_W-1:0] s_now_ms,
    // Result channel.
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_fetch_request,
    output logic              m_key_is_bad,
    output logic              m_already_have,
    output logic [GEN_W-1:0]  m_generation,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CNT_W-1:0] slots_in_use_reg;
    queue_out_t       queue_word;
    logic             queue_pop;

    // The only register answers wherever paddr[2] is low; other addresses read as zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(slots_in_use_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= CNT_W'(16);
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            slots_in_use_reg <= pwdata[CNT_W-1:0];
        end
    end

    // The front masks the key to KEY_BITS and queues the classified word.
    lsc_front #(
        .KEY_BITS(KEY_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_key          (s_key),
        .s_fetch_allowed(s_fetch_allowed),
        .s_target_slot  (s_target_slot),
        .s_decode_ok    (s_decode_ok),
        .s_now_ms       (s_now_ms),
        .q_out          (queue_word),
        .q_pop          (queue_pop)
    );

    // The back owns every store and applies one word at a time.
    lsc_back #(
        .SLOT_COUNT(SLOT_COUNT),
        .BAD_DEPTH (BAD_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .slots_in_use   (slots_in_use_reg),
        .q_in           (queue_word),
        .q_pop          (queue_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_slot         (m_slot),
        .m_fetch_request(m_fetch_request),
        .m_key_is_bad   (m_key_is_bad),
        .m_already_have (m_already_have),
        .m_generation   (m_generation)
    );

endmodule
